@@ hdl/sud_pkg.sv @@
// Shared constants and types for the signed/unsigned divider.
package sud_pkg;

  localparam int SUD_DATA_WIDTH = 64;

  // Sign and special-case flags that travel alongside each request.
  typedef struct packed {
    logic neg_quot;
    logic neg_rem;
    logic div_zero;
  } sud_ctrl_t;

endpackage

@@ hdl/sud_if.sv @@
// Request and result channel interfaces of the divider.
interface sud_req_if #(parameter int DATA_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  modport source (output valid, output action, output dividend, output divisor, input ready);
  modport sink   (input valid, input action, input dividend, input divisor, output ready);
endinterface

interface sud_rsp_if #(parameter int DATA_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder_out;
  logic                  divide_by_zero;

  modport source (output valid, output quotient, output remainder_out, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder_out, input divide_by_zero,
                  output ready);
endinterface

@@ hdl/sud_pre.sv @@
// Input stage: takes magnitudes of signed operands and flags a zero divisor.
module sud_pre import sud_pkg::*; #(
  parameter int DATA_WIDTH = SUD_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  sud_req_if.sink               req,
  output logic                  out_valid,
  output sud_ctrl_t             out_ctrl,
  output logic [DATA_WIDTH-1:0] out_num,
  output logic [DATA_WIDTH-1:0] out_den
);

  logic                  neg_a;
  logic                  neg_b;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  sud_ctrl_t             ctrl_next;

  assign req.ready = en;

  always_comb begin
    neg_a = req.action & req.dividend[DATA_WIDTH-1];
    neg_b = req.action & req.divisor[DATA_WIDTH-1];
    mag_a = neg_a ? (~req.dividend + DATA_WIDTH'(1)) : req.dividend;
    mag_b = neg_b ? (~req.divisor + DATA_WIDTH'(1)) : req.divisor;
    ctrl_next.neg_quot = neg_a ^ neg_b;
    ctrl_next.neg_rem  = neg_a;
    ctrl_next.div_zero = (req.divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl <= ctrl_next;
      out_num  <= mag_a;
      out_den  <= mag_b;
    end
  end

endmodule

@@ hdl/sud_cell.sv @@
// One restoring division step: produces one quotient bit per cell.
module sud_cell import sud_pkg::*; #(
  parameter int DATA_WIDTH = SUD_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sud_ctrl_t             in_ctrl,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_aq,
  input  logic [DATA_WIDTH-1:0] in_den,
  output logic                  out_valid,
  output sud_ctrl_t             out_ctrl,
  output logic [DATA_WIDTH-1:0] out_rem,
  output logic [DATA_WIDTH-1:0] out_aq,
  output logic [DATA_WIDTH-1:0] out_den
);

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] aq_next;

  // The partial remainder keeps the bit shifted out of its top, so the
  // trial value is one bit wider than the divisor.
  always_comb begin
    trial    = {in_rem, in_aq[DATA_WIDTH-1]};
    diff     = trial - {1'b0, in_den};
    fits     = ~diff[DATA_WIDTH];
    rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    aq_next  = {in_aq[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl <= in_ctrl;
      out_rem  <= rem_next;
      out_aq   <= aq_next;
      out_den  <= in_den;
    end
  end

endmodule

@@ hdl/sud_post.sv @@
// Output stage: restores signs, forces zero-divisor results and holds the result register.
module sud_post import sud_pkg::*; #(
  parameter int DATA_WIDTH = SUD_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  sud_ctrl_t             in_ctrl,
  input  logic [DATA_WIDTH-1:0] in_rem,
  input  logic [DATA_WIDTH-1:0] in_quot,
  sud_rsp_if.source             rsp
);

  logic [DATA_WIDTH-1:0] quot_next;
  logic [DATA_WIDTH-1:0] rem_next;

  always_comb begin
    quot_next = in_ctrl.neg_quot ? (~in_quot + DATA_WIDTH'(1)) : in_quot;
    rem_next  = in_ctrl.neg_rem ? (~in_rem + DATA_WIDTH'(1)) : in_rem;
    if (in_ctrl.div_zero) begin
      quot_next = '0;
      rem_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.quotient       <= quot_next;
      rsp.remainder_out  <= rem_next;
      rsp.divide_by_zero <= in_ctrl.div_zero;
    end
  end

endmodule

@@ hdl/signed_unsigned_divider_64_unit.sv @@
// Pipelined signed/unsigned restoring divider built as a chain of one-bit cells.
// Stages in order: input stage, DATA_WIDTH cells, result register.
// Throughput: one request per cycle while the chain is not stalled; each cell's subtract decides one quotient bit.
// A result held in the result register stalls the whole chain until it is taken.
// Synchronous reset clears only the valid bits of the stages.
module signed_unsigned_divider_64_unit import sud_pkg::*; #(
  parameter int DATA_WIDTH = SUD_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  sud_req_if.sink   req,
  sud_rsp_if.source rsp
);

  logic                  advance;
  logic                  stage_valid [0:DATA_WIDTH];
  sud_ctrl_t             stage_ctrl  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stage_rem   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stage_aq    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] stage_den   [0:DATA_WIDTH];

  // The chain moves whenever the result register is empty or being read.
  assign advance      = ~rsp.valid | rsp.ready;
  assign stage_rem[0] = '0;

  sud_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .req       (req),
    .out_valid (stage_valid[0]),
    .out_ctrl  (stage_ctrl[0]),
    .out_num   (stage_aq[0]),
    .out_den   (stage_den[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sud_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (stage_valid[i]),
      .in_ctrl   (stage_ctrl[i]),
      .in_rem    (stage_rem[i]),
      .in_aq     (stage_aq[i]),
      .in_den    (stage_den[i]),
      .out_valid (stage_valid[i+1]),
      .out_ctrl  (stage_ctrl[i+1]),
      .out_rem   (stage_rem[i+1]),
      .out_aq    (stage_aq[i+1]),
      .out_den   (stage_den[i+1])
    );
  end

  sud_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (stage_valid[DATA_WIDTH]),
    .in_ctrl  (stage_ctrl[DATA_WIDTH]),
    .in_rem   (stage_rem[DATA_WIDTH]),
    .in_quot  (stage_aq[DATA_WIDTH]),
    .rsp      (rsp)
  );

endmodule

@@ test/tb_signed_unsigned_divider_64_unit.sv @@
// Self-checking testbench for the pipelined signed/unsigned 64-bit divider.
module tb_signed_unsigned_divider_64_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sud_pkg::*;

  localparam int W = SUD_DATA_WIDTH;
  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED = 1'b1;
  localparam int RANDOM_REQUESTS = 550;
  localparam int CALM_REQUESTS = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  typedef struct {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         div_zero;
  } div_result_t;

  class division_checker;
    div_result_t pending[$];
    int unsigned failures;

    function div_result_t predict_division(logic signed_mode, logic [W-1:0] a,
                                           logic [W-1:0] b);
      div_result_t res;
      logic neg_a;
      logic neg_b;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] q;
      logic [W:0] part;
      res.quotient = '0;
      res.remainder = '0;
      res.div_zero = 1'b0;
      if (b == '0) begin
        res.div_zero = 1'b1;
        return res;
      end
      neg_a = signed_mode && a[W-1];
      neg_b = signed_mode && b[W-1];
      mag_a = neg_a ? -a : a;
      mag_b = neg_b ? -b : b;
      q = '0;
      part = '0;
      // The partial remainder is one bit wider, so the bit shifted out of the top is kept.
      for (int i = W - 1; i >= 0; i--) begin
        part = {part[W-1:0], mag_a[i]};
        if (part >= {1'b0, mag_b}) begin
          part = part - {1'b0, mag_b};
          q[i] = 1'b1;
        end
      end
      res.quotient = (neg_a != neg_b) ? -q : q;
      res.remainder = neg_a ? -part[W-1:0] : part[W-1:0];
      return res;
    endfunction

    function void note_request(logic signed_mode, logic [W-1:0] a, logic [W-1:0] b);
      pending.push_back(predict_division(signed_mode, a, b));
    endfunction

    function void check_result(logic [W-1:0] q, logic [W-1:0] r, logic dz);
      div_result_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result q=%h r=%h dz=%b", $realtime, q, r, dz);
        return;
      end
      want = pending.pop_front();
      if (q !== want.quotient || r !== want.remainder || dz !== want.div_zero) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch q=%h r=%h dz=%b, expected q=%h r=%h dz=%b", $realtime,
                   q, r, dz, want.quotient, want.remainder, want.div_zero);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic calm = 1'b0;
  int unsigned cycles = 0;
  division_checker div_board = new();

  sud_req_if #(.DATA_WIDTH(W)) req_ch ();
  sud_rsp_if #(.DATA_WIDTH(W)) rsp_ch ();

  signed_unsigned_divider_64_unit #(.DATA_WIDTH(W)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      div_board.check_result(rsp_ch.quotient, rsp_ch.remainder_out, rsp_ch.divide_by_zero);
  end

  // Result side: runs of ready broken by stalls, with no stalls once the run turns calm.
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!calm && $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_division(input logic mode, input logic [W-1:0] a,
                               input logic [W-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= mode;
    req_ch.dividend <= a;
    req_ch.divisor <= b;
    do @(posedge clk); while (!req_ch.ready);
    div_board.note_request(mode, a, b);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (div_board.pending.size() != 0) @(negedge clk);
  endtask

  // Mixes full-range values, values of random bit length, small values and boundaries.
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      5, 6, 7: v = v >> $urandom_range(0, W - 1);
      8: begin
        v = W'($urandom_range(0, 15));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      9: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = ALL_ONES;
          3: v = W'(1);
          default: v = '0;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = MODE_UNSIGNED;
    req_ch.dividend = '0;
    req_ch.divisor = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_division(MODE_UNSIGNED, W'(100), W'(7));
    send_division(MODE_UNSIGNED, ALL_ONES, '0);
    send_division(MODE_SIGNED, MOST_NEG, '0);
    send_division(MODE_UNSIGNED, '0, '0);
    send_division(MODE_SIGNED, MOST_NEG, ALL_ONES);
    send_division(MODE_SIGNED, MOST_POS, ALL_ONES);
    send_division(MODE_UNSIGNED, MOST_NEG, ALL_ONES);
    send_division(MODE_UNSIGNED, ALL_ONES, ALL_ONES);
    send_division(MODE_UNSIGNED, ALL_ONES, W'(1));
    send_division(MODE_UNSIGNED, ALL_ONES, W'(3));
    send_division(MODE_SIGNED, MOST_NEG, W'(1));
    send_division(MODE_SIGNED, MOST_POS, MOST_NEG);
    send_division(MODE_SIGNED, MOST_NEG, MOST_NEG);
    send_division(MODE_SIGNED, MOST_NEG, MOST_POS);
    send_division(MODE_SIGNED, -64'sd7, 64'sd2);
    send_division(MODE_SIGNED, 64'sd7, -64'sd2);
    send_division(MODE_SIGNED, -64'sd7, -64'sd2);
    send_division(MODE_SIGNED, ALL_ONES, MOST_POS);
    send_division(MODE_SIGNED, '0, -64'sd5);
    // Divisors with the top bit set exercise the carry out of the partial remainder.
    send_division(MODE_UNSIGNED, ALL_ONES, MOST_NEG);
    send_division(MODE_UNSIGNED, MOST_NEG + W'(5), MOST_NEG + W'(3));
    send_division(MODE_UNSIGNED, W'(3), ALL_ONES);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) wait_for_drain();
      if (n == RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
      send_division(logic'($urandom_range(0, 1)), random_operand(), random_operand());
    end

    wait_for_drain();
    repeat (W + 10) @(negedge clk);
    div_board.failures += div_board.pending.size();
    if (div_board.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
